FILE: rtl/aar_pkg.sv
// ----------------------------------------------------------------------------
// aar_pkg
// Shared types and constants of the axis-angle to rotation matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aar_pkg;

  // Number of CORDIC cells and datapath widths
  localparam int STEPS = 24;
  localparam int CW    = 33;   // x/y width, Q2.30 plus headroom
  localparam int ZW    = 32;   // residual angle width

  // Gain-compensated 1.0 in Q2.30
  localparam logic signed [CW-1:0] X_INIT = 33'sd652032874;

  // One input item
  typedef struct packed {
    logic signed [23:0] angle_deg;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_item_t;

  // Rotation axis carried alongside the CORDIC chain
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } axis_t;

  // Word handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic [1:0]           quad;
    axis_t                axis;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // Arctangent of 2^-idx as a 32-bit binary angle
  function automatic logic signed [ZW-1:0] atan_val(input int idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:       a = 32'sd536870912;
      1:       a = 32'sd316933406;
      2:       a = 32'sd167458907;
      3:       a = 32'sd85004756;
      4:       a = 32'sd42667331;
      5:       a = 32'sd21354465;
      6:       a = 32'sd10679838;
      7:       a = 32'sd5340245;
      8:       a = 32'sd2670163;
      9:       a = 32'sd1335087;
      10:      a = 32'sd667544;
      11:      a = 32'sd333772;
      12:      a = 32'sd166886;
      13:      a = 32'sd83443;
      14:      a = 32'sd41722;
      15:      a = 32'sd20861;
      16:      a = 32'sd10430;
      17:      a = 32'sd5215;
      18:      a = 32'sd2608;
      19:      a = 32'sd1304;
      20:      a = 32'sd652;
      21:      a = 32'sd326;
      22:      a = 32'sd163;
      23:      a = 32'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/aar_if.sv
// ----------------------------------------------------------------------------
// aar_if
// Valid/ready channels for axis-angle items and rotation matrix results.
// ----------------------------------------------------------------------------
`default_nettype none

interface aar_axis_angle_if;
  logic              valid;
  logic              ready;
  aar_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aar_matrix_if;
  logic               valid;
  logic               ready;
  aar_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/axis_angle_to_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix_unit
// Angle (1/256 degree) and unit axis (Q1.15) in, 3x3 rotation matrix out.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the output is not stalled and
// returns one matrix per item, in order: the phase block maps the half angle
// to a binary phase, a row of 24 CORDIC cells forms cosine and sine, and
// the output block scales the axis, forms the products and rounds each entry
// to a saturated Q1.15 value. The whole pipeline holds while a finished matrix
// waits at the output register, so input ready follows output ready.
`default_nettype none

module axis_angle_to_rotation_matrix_unit (
  input  logic                clk,
  input  logic                rst,
  aar_axis_angle_if.sink      axis_angle,
  aar_matrix_if.source        matrix
);
  import aar_pkg::*;

  logic    adv;
  cordic_t chain [0:STEPS];

  // Move the pipeline unless a result is stuck at the output
  assign adv              = !matrix.valid || matrix.ready;
  assign axis_angle.ready = adv;

  aar_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .din_valid (axis_angle.valid),
    .din       (axis_angle.data),
    .dout      (chain[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    aar_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  aar_matrix_form u_form (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .din   (chain[STEPS]),
    .valid (matrix.valid),
    .data  (matrix.data)
  );

`ifndef SYNTHESIS
  // A stalled pipeline keeps the CORDIC result in place
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(chain[STEPS]))
    else $error("CORDIC output changed during stall");

  // The residual angle has converged after the last cell
  a_residual: assert property (@(posedge clk) disable iff (rst)
    chain[STEPS].valid |-> (chain[STEPS].z < 32'sd1024 && chain[STEPS].z > -32'sd1024))
    else $error("CORDIC residual did not converge");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !matrix.valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

FILE: rtl/aar_phase.sv
// ----------------------------------------------------------------------------
// aar_phase
// Maps the half angle to a binary phase, quadrant and CORDIC start word.
// ----------------------------------------------------------------------------
`default_nettype none

module aar_phase (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              din_valid,
  input  aar_pkg::in_item_t din,
  output aar_pkg::cordic_t  dout
);
  import aar_pkg::*;

  // Offset that is a multiple of 45 and lifts the angle above zero
  localparam logic [24:0] OFFSET    = 25'd8388630;
  localparam logic [25:0] RECIP_45  = 26'd47721859;   // ceil(2^31 / 45)
  localparam logic [26:0] FRAC_45   = 27'd95443718;   // ceil(2^32 / 45)
  localparam logic [11:0] TURN_OFFS = 12'd2094;       // (OFFSET / 45) mod 4096

  logic        v1, v2, v3, v4;
  axis_t       ax1, ax2, ax3;
  logic [24:0] u1, u2;
  logic [18:0] q2;
  logic [5:0]  b3;
  logic [11:0] ql3;

  logic [24:0] u_c;
  logic [50:0] qprod;
  logic [24:0] rem_c;
  logic [32:0] fprod;
  logic [31:0] phase;
  logic [31:0] tphase;
  cordic_t     start_c;
  cordic_t     dat;

  // Offset angle, unsigned
  assign u_c   = 25'(din.angle_deg) + OFFSET;
  // Quotient by reciprocal multiply
  assign qprod = 51'(u1) * 51'(RECIP_45);
  // Remainder of the division by 45
  assign rem_c = u2 - 25'(q2) * 25'd45;
  // Fraction of a turn from the remainder, then quadrant split
  assign fprod  = 33'(b3) * 33'(FRAC_45);
  assign phase  = {ql3, fprod[31:12]};
  assign tphase = phase + 32'h2000_0000;

  always_comb begin
    start_c.valid = v3;
    start_c.quad  = tphase[31:30];
    start_c.axis  = ax3;
    start_c.x     = X_INIT;
    start_c.y     = '0;
    start_c.z     = $signed({2'b00, tphase[29:0]}) - 32'sd536870912;
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= din_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (adv) begin
      u1  <= u_c;
      ax1 <= '{x: din.axis_x, y: din.axis_y, z: din.axis_z};
      u2  <= u1;
      q2  <= qprod[49:31];
      ax2 <= ax1;
      b3  <= rem_c[5:0];
      ql3 <= q2[11:0] - TURN_OFFS;
      ax3 <= ax2;
      dat <= start_c;
    end
  end

  always_comb begin
    dout       = dat;
    dout.valid = v4;
  end

endmodule

`default_nettype wire

FILE: rtl/aar_cordic_cell.sv
// ----------------------------------------------------------------------------
// aar_cordic_cell
// One CORDIC rotation step in rotation mode, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module aar_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  aar_pkg::cordic_t din,
  output aar_pkg::cordic_t dout
);
  import aar_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = atan_val(STEP);

  logic                 vld;
  cordic_t              dat;
  cordic_t              nxt;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  assign xs = din.x >>> STEP;
  assign ys = din.y >>> STEP;

  // Rotate toward zero residual
  always_comb begin
    nxt = din;
    if (!din.z[ZW-1]) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - ANGLE;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat <= nxt;
    end
  end

  always_comb begin
    dout       = dat;
    dout.valid = vld;
  end

endmodule

`default_nettype wire

FILE: rtl/aar_matrix_form.sv
// ----------------------------------------------------------------------------
// aar_matrix_form
// Places cos/sin by quadrant, scales the axis and forms the nine entries.
// ----------------------------------------------------------------------------
`default_nettype none

module aar_matrix_form (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  aar_pkg::cordic_t   din,
  output logic               valid,
  output aar_pkg::out_item_t data
);
  import aar_pkg::*;

  localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

  // Scale a Q2.30 value by a Q1.15 axis term with rounding
  function automatic logic signed [CW-1:0] scale_axis(input logic signed [15:0] a,
                                                      input logic signed [CW-1:0] s);
    logic signed [49:0] p;
    p = 50'(a) * 50'(s) + 50'sd16384;
    return p[47:15];
  endfunction

  // Doubled product in Q2.30 with rounding
  function automatic logic signed [33:0] mul_rnd(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + 66'sd268435456;
    return p[62:29];
  endfunction

  // Round to Q1.15 and saturate
  function automatic logic signed [15:0] sat_q15(input logic signed [35:0] e);
    logic signed [35:0] r;
    r = (e + 36'sd16384) >>> 15;
    if (r > 36'sd32767) begin
      return 16'sh7fff;
    end else if (r < -36'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  logic v1, v2, v3, v4, v5;

  logic signed [CW-1:0] c1, s1, c2;
  axis_t                ax1;
  logic signed [CW-1:0] vx2, vy2, vz2;
  logic signed [33:0]   xx3, xy3, xz3, yy3, yz3, zz3, wx3, wy3, wz3;
  logic signed [35:0]   e4 [0:8];

  logic signed [CW-1:0] c_c, s_c;
  logic signed [35:0]   e_c [0:8];
  out_item_t            res_c;

  // Rotate cos/sin into the quadrant
  always_comb begin
    case (din.quad)
      2'd0:    begin c_c = din.x;  s_c = din.y;  end
      2'd1:    begin c_c = -din.y; s_c = din.x;  end
      2'd2:    begin c_c = -din.x; s_c = -din.y; end
      default: begin c_c = din.y;  s_c = -din.x; end
    endcase
  end

  // Matrix entries in Q2.30
  always_comb begin
    e_c[0] = ONE_Q30 - (36'(yy3) + 36'(zz3));
    e_c[1] = 36'(xy3) - 36'(wz3);
    e_c[2] = 36'(xz3) + 36'(wy3);
    e_c[3] = 36'(xy3) + 36'(wz3);
    e_c[4] = ONE_Q30 - (36'(xx3) + 36'(zz3));
    e_c[5] = 36'(yz3) - 36'(wx3);
    e_c[6] = 36'(xz3) - 36'(wy3);
    e_c[7] = 36'(yz3) + 36'(wx3);
    e_c[8] = ONE_Q30 - (36'(xx3) + 36'(yy3));
  end

  always_comb begin
    res_c.m00 = sat_q15(e4[0]);
    res_c.m01 = sat_q15(e4[1]);
    res_c.m02 = sat_q15(e4[2]);
    res_c.m10 = sat_q15(e4[3]);
    res_c.m11 = sat_q15(e4[4]);
    res_c.m12 = sat_q15(e4[5]);
    res_c.m20 = sat_q15(e4[6]);
    res_c.m21 = sat_q15(e4[7]);
    res_c.m22 = sat_q15(e4[8]);
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= din.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (adv) begin
      c1  <= c_c;
      s1  <= s_c;
      ax1 <= din.axis;
      c2  <= c1;
      vx2 <= scale_axis(ax1.x, s1);
      vy2 <= scale_axis(ax1.y, s1);
      vz2 <= scale_axis(ax1.z, s1);
      xx3 <= mul_rnd(vx2, vx2);
      xy3 <= mul_rnd(vx2, vy2);
      xz3 <= mul_rnd(vx2, vz2);
      yy3 <= mul_rnd(vy2, vy2);
      yz3 <= mul_rnd(vy2, vz2);
      zz3 <= mul_rnd(vz2, vz2);
      wx3 <= mul_rnd(c2, vx2);
      wy3 <= mul_rnd(c2, vy2);
      wz3 <= mul_rnd(c2, vz2);
      e4  <= e_c;
      data <= res_c;
    end
  end

  assign valid = v5;

endmodule

`default_nettype wire

FILE: dv/aar_rotation_checker.sv
// ----------------------------------------------------------------------------
// aar_rotation_checker
// Watches the axis-angle and matrix channels, forms the expected rotation
// matrix of every transferred item and compares the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module aar_rotation_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  aar_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  aar_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import aar_pkg::*;

  localparam longint ONE_Q30    = 64'sd1073741824;
  localparam longint TURN_UNITS = 64'sd184320;

  out_item_t matrix_q[$];

  // Floor shift and round-half-up shift
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] sat_q15(longint e);
    longint r;
    r = round_shift(e, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Half-angle cosine and sine in Q2.30
  function automatic void half_angle_sincos(input longint ang, output longint c,
                                            output longint s);
    longint r, x, y, z, nx;
    logic [31:0] ph, pq;
    logic [1:0] quad;
    r = ang % TURN_UNITS;
    if (r < 0) r += TURN_UNITS;
    ph = 32'((r <<< 20) / 45);
    pq = ph + 32'h2000_0000;
    quad = pq[31:30];
    z = longint'({2'b00, pq[29:0]}) - 64'sh2000_0000;
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= longint'(atan_val(i));
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += longint'(atan_val(i));
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic out_item_t rotation_matrix(in_item_t it);
    out_item_t m;
    longint c, s, x, y, z, xx, xy, xz, yy, yz, zz, wx, wy, wz;
    half_angle_sincos(longint'(it.angle_deg), c, s);
    x = round_shift(longint'(it.axis_x) * s, 15);
    y = round_shift(longint'(it.axis_y) * s, 15);
    z = round_shift(longint'(it.axis_z) * s, 15);
    xx = round_shift(x * x, 29);
    xy = round_shift(x * y, 29);
    xz = round_shift(x * z, 29);
    yy = round_shift(y * y, 29);
    yz = round_shift(y * z, 29);
    zz = round_shift(z * z, 29);
    wx = round_shift(c * x, 29);
    wy = round_shift(c * y, 29);
    wz = round_shift(c * z, 29);
    m.m00 = sat_q15(ONE_Q30 - (yy + zz));
    m.m01 = sat_q15(xy - wz);
    m.m02 = sat_q15(xz + wy);
    m.m10 = sat_q15(xy + wz);
    m.m11 = sat_q15(ONE_Q30 - (xx + zz));
    m.m12 = sat_q15(yz - wx);
    m.m20 = sat_q15(xz - wy);
    m.m21 = sat_q15(yz + wx);
    m.m22 = sat_q15(ONE_Q30 - (xx + yy));
    return m;
  endfunction

  function automatic int report_entry(string name, logic signed [15:0] exp_v,
                                      logic signed [15:0] act_v);
    if (exp_v === act_v) return 0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    return 1;
  endfunction

  assign pending = matrix_q.size();

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) matrix_q.push_back(rotation_matrix(in_data));
      if (out_valid && out_ready) begin
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected matrix, got %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = matrix_q.pop_front();
          fail_count <= fail_count
            + report_entry("m00", e.m00, out_data.m00) + report_entry("m01", e.m01, out_data.m01)
            + report_entry("m02", e.m02, out_data.m02) + report_entry("m10", e.m10, out_data.m10)
            + report_entry("m11", e.m11, out_data.m11) + report_entry("m12", e.m12, out_data.m12)
            + report_entry("m20", e.m20, out_data.m20) + report_entry("m21", e.m21, out_data.m21)
            + report_entry("m22", e.m22, out_data.m22);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/axis_angle_to_rotation_matrix_unit_tb.sv
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix_unit_tb
// Drives directed and random axis-angle items with random gaps and output
// stalls; the checker predicts every matrix and compares it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module axis_angle_to_rotation_matrix_unit_tb;
  import aar_pkg::*;

  localparam int RANDOM_ITEMS = 1130;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  logic stall_on = 1'b1;

  aar_axis_angle_if axis_angle ();
  aar_matrix_if     matrix ();

  always #1 clk = ~clk;

  axis_angle_to_rotation_matrix_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .axis_angle (axis_angle.sink),
    .matrix     (matrix.source)
  );

  aar_rotation_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (axis_angle.valid),
    .in_ready   (axis_angle.ready),
    .in_data    (axis_angle.data),
    .out_valid  (matrix.valid),
    .out_ready  (matrix.ready),
    .out_data   (matrix.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic signed [15:0] axis_value();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 2047)) - 16'sd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one item at the falling edge and hold it until transferred
  task automatic send_item(input in_item_t it);
    int gap;
    gap = stall_on ? gap_length() : 0;
    repeat (gap) begin
      @(negedge clk);
      axis_angle.valid <= 1'b0;
    end
    @(negedge clk);
    axis_angle.valid <= 1'b1;
    axis_angle.data  <= it;
    do @(posedge clk); while (!axis_angle.ready);
  endtask

  // Random output stalls, with a quiet stretch in the middle of the run
  always @(negedge clk) begin
    if (rst || !stall_on) matrix.ready <= 1'b1;
    else if ($urandom_range(0, 29) == 0) matrix.ready <= 1'b0;
    else if (!matrix.ready && $urandom_range(0, 3) != 0) matrix.ready <= 1'b0;
    else matrix.ready <= 1'b1;
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((axis_angle.valid && axis_angle.ready) || (matrix.valid && matrix.ready) || rst)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    axis_angle.valid = 1'b0;
    axis_angle.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: angle extremes and quadrants, axis extremes
    for (int k = 0; k < 24; k++) begin
      case (k)
        0: it.angle_deg = 24'sh000000;
        1: it.angle_deg = 24'sh7fffff;
        2: it.angle_deg = 24'sh800000;
        3: it.angle_deg = 24'sd23040;
        4: it.angle_deg = 24'sd46080;
        5: it.angle_deg = 24'sd69120;
        6: it.angle_deg = 24'sd92160;
        7: it.angle_deg = -24'sd23040;
        8: it.angle_deg = 24'sd11520;
        9: it.angle_deg = 24'sd184320;
        10: it.angle_deg = 24'sd1;
        11: it.angle_deg = -24'sd1;
        default: it.angle_deg = 24'($urandom);
      endcase
      case (k % 4)
        0: begin it.axis_x = 16'sh7fff; it.axis_y = '0; it.axis_z = '0; end
        1: begin it.axis_x = '0; it.axis_y = 16'sh8000; it.axis_z = 16'sh7fff; end
        2: begin it.axis_x = 16'sh8000; it.axis_y = 16'sh8000; it.axis_z = 16'sh8000; end
        default: begin
          it.axis_x = 16'sd18918; it.axis_y = 16'sd18918; it.axis_z = 16'sd18918;
        end
      endcase
      send_item(it);
    end

    // Random items; a stretch without any idling on either side
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      stall_on = !(n >= 400 && n < 550);
      it.angle_deg = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                 : 24'($urandom_range(0, 184320)) - 24'sd92160;
      it.axis_x = axis_value();
      it.axis_y = axis_value();
      it.axis_z = axis_value();
      send_item(it);
    end
    @(negedge clk);
    axis_angle.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: axis_angle_to_rotation_matrix_unit.f
rtl/aar_pkg.sv
rtl/aar_if.sv
rtl/aar_phase.sv
rtl/aar_cordic_cell.sv
rtl/aar_matrix_form.sv
rtl/axis_angle_to_rotation_matrix_unit.sv
dv/aar_rotation_checker.sv
dv/axis_angle_to_rotation_matrix_unit_tb.sv
